// File: hw/rtl/rvw_pkg.sv
// Shared widths for the running variance block.
// Used by every module under hw/rtl; no dependencies.
package rvw_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int SAMPLE_BITS = 32;

    localparam int MEAN_W  = SAMPLE_BITS + 16;   // Q32.16 running mean
    localparam int DIFF_W  = MEAN_W + 1;         // difference of a sample and the mean
    localparam int M2_W    = 64;
    localparam int VAR_W   = 48;
    localparam int DEV_W   = 32;
    localparam int DIVD_W  = 64;
    localparam int DIVS_W  = COUNT_BITS;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SQ_IN_W = 64;

    localparam logic [VAR_W-1:0]      VAR_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

endpackage

// File: hw/rtl/rvw_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rvw_pkg.
module rvw_div import rvw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIVD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVS_W-1:0] r_div;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quot;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;

    assign trial = {r_rem, r_quot[DIVD_W-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            r_quot <= {r_quot[DIVD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: hw/rtl/rvw_mul.sv
// Unsigned multiplier built from four partial products on one small
// multiplier, then accumulated. Depends on rvw_pkg.
module rvw_mul import rvw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIFF_W-1:0] i_a,
    input  logic [DIFF_W-1:0] i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);

    localparam int LO_W = DIFF_W / 2;
    localparam int HI_W = DIFF_W - LO_W;
    localparam int PP_W = 2 * HI_W;

    logic              r_busy;
    logic              r_done;
    logic [2:0]        r_cnt;
    logic [DIFF_W-1:0] r_a;
    logic [DIFF_W-1:0] r_b;
    logic [PP_W-1:0]   r_pp;
    logic [1:0]        r_pp_idx;
    logic [PROD_W-1:0] r_acc;
    logic [HI_W-1:0]   op_a;
    logic [HI_W-1:0]   op_b;
    logic [PROD_W-1:0] pp_shifted;

    always_comb begin
        op_a = r_cnt[1] ? r_a[DIFF_W-1:LO_W] : HI_W'(r_a[LO_W-1:0]);
        op_b = r_cnt[0] ? r_b[DIFF_W-1:LO_W] : HI_W'(r_b[LO_W-1:0]);
        case (r_pp_idx)
            2'd0:    pp_shifted = PROD_W'(r_pp);
            2'd1,
            2'd2:    pp_shifted = PROD_W'(r_pp) << LO_W;
            default: pp_shifted = PROD_W'(r_pp) << (2 * LO_W);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt != 3'd4) begin
                r_pp     <= op_a * op_b;
                r_pp_idx <= r_cnt[1:0];
            end
            if (r_cnt != 3'd0) begin
                r_acc <= r_acc + pp_shifted;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: hw/rtl/rvw_sqrt.sv
// Digit-by-digit floor square root, one result bit per cycle.
// Depends on rvw_pkg.
module rvw_sqrt import rvw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SQ_IN_W-1:0] i_val,
    output logic               o_done,
    output logic [DEV_W-1:0]   o_root
);

    localparam int CNT_W = $clog2(DEV_W);
    localparam int REM_W = DEV_W + 2;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [SQ_IN_W-1:0] r_v;
    logic [REM_W-1:0]   r_rem;
    logic [DEV_W-1:0]   r_root;
    logic [REM_W+1:0]   rem2;
    logic [REM_W+1:0]   trial;
    logic               ge;

    assign rem2  = {r_rem, r_v[SQ_IN_W-1 -: 2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DEV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v    <= r_v << 2;
            r_rem  <= ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
            r_root <= {r_root[DEV_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: hw/rtl/running_variance_welford.sv
// Running variance (Welford) top level: sequencer, state and output register.
// Depends on rvw_pkg, rvw_div, rvw_mul, rvw_sqrt.
//
// Input channel i_valid/o_stall carries one sample per request, with an
// absent mark and a group end mark. Output channel o_valid/i_stall carries
// one result per group end: both variances, both deviations, count, flags.
// The block works on one request at a time; o_stall is high while busy.
// A present sample runs the mean step on the shared divider, then the
// partial-product multiplier and an accumulate step, before the next
// request is accepted. An absent sample without group end is taken
// without leaving the idle state. A group end adds two divider passes
// (skipped for fewer than one or two samples), two square root passes and
// an output step.
// The result sits in an output register; the block accepts the next request
// while it waits, but a following group end holds in the final step until
// the receiver takes the previous result. Synchronous active-low reset
// clears all accumulated state and drops o_valid.
module running_variance_welford import rvw_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_sample_absent,
    input  logic                   i_group_end,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [VAR_W-1:0]       o_variance_population,
    output logic [VAR_W-1:0]       o_variance_sample,
    output logic [DEV_W-1:0]       o_deviation_population,
    output logic [DEV_W-1:0]       o_deviation_sample,
    output logic [31:0]            o_sample_count,
    output logic                   o_population_valid,
    output logic                   o_sample_stats_valid,
    output logic                   o_overflow_flag
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DIV_MEAN = 9'b000000010,
        S_MUL      = 9'b000000100,
        S_ACC      = 9'b000001000,
        S_DIV_VP   = 9'b000010000,
        S_DIV_VS   = 9'b000100000,
        S_SQ_VP    = 9'b001000000,
        S_SQ_VS    = 9'b010000000,
        S_OUT      = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic signed [MEAN_W-1:0] r_mean;
    logic signed [MEAN_W-1:0] r_xq;
    logic signed [DIFF_W-1:0] r_delta;
    logic [M2_W-1:0]          r_m2;
    logic [COUNT_BITS-1:0]    r_count;
    logic                     r_sat;
    logic                     r_end;
    logic                     r_launch;
    logic [VAR_W-1:0]         r_vp;
    logic [VAR_W-1:0]         r_vs;
    logic [DEV_W-1:0]         r_dp;
    logic                     r_o_valid;

    logic                     accept;
    logic                     out_free;
    logic signed [MEAN_W-1:0] xq_in;
    logic signed [DIFF_W-1:0] delta_in;
    logic [DIFF_W-1:0]        delta_mag;
    logic signed [DIFF_W-1:0] dev2;
    logic [DIFF_W-1:0]        dev2_mag;
    logic [DIFF_W-1:0]        quot_part;
    logic signed [DIFF_W-1:0] mean_next;
    logic [M2_W:0]            m2_sum;
    logic [VAR_W-1:0]         quot_clamped;
    logic                     cnt_ge1;
    logic                     cnt_ge2;

    logic              div_start, div_done;
    logic [DIVD_W-1:0] div_dividend, div_quot;
    logic [DIVS_W-1:0] div_divisor;
    logic              mul_start, mul_done;
    logic [PROD_W-1:0] mul_prod;
    logic              sq_start, sq_done;
    logic [SQ_IN_W-1:0] sq_val;
    logic [DEV_W-1:0]  sq_root;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_o_valid || !i_stall;
    assign cnt_ge1  = (r_count != '0);
    assign cnt_ge2  = (r_count > COUNT_BITS'(1));

    assign xq_in     = {i_sample, 16'h0000};
    assign delta_in  = DIFF_W'(xq_in) - DIFF_W'(r_mean);
    assign delta_mag = r_delta[DIFF_W-1] ? DIFF_W'(-r_delta) : DIFF_W'(r_delta);
    assign dev2      = DIFF_W'(r_xq) - DIFF_W'(r_mean);
    assign dev2_mag  = dev2[DIFF_W-1] ? DIFF_W'(-dev2) : DIFF_W'(dev2);
    assign quot_part = div_quot[DIFF_W-1:0];
    // truncating division: magnitude quotient takes the sign of the delta
    assign mean_next = DIFF_W'(r_mean)
                     + (r_delta[DIFF_W-1] ? DIFF_W'(-quot_part) : DIFF_W'(quot_part));
    assign m2_sum    = {1'b0, r_m2} + (M2_W + 1)'(mul_prod[PROD_W-1:48]);
    assign quot_clamped = (div_quot > DIVD_W'(VAR_MAX)) ? VAR_MAX : div_quot[VAR_W-1:0];

    // shared unit operand selection
    always_comb begin
        case (r_state)
            S_DIV_MEAN: begin
                div_dividend = DIVD_W'(delta_mag);
                div_divisor  = r_count;
            end
            S_DIV_VS: begin
                div_dividend = r_m2;
                div_divisor  = r_count - 1'b1;
            end
            default: begin
                div_dividend = r_m2;
                div_divisor  = r_count;
            end
        endcase
        sq_val = (r_state == S_SQ_VS) ? {r_vs, 16'h0000} : {r_vp, 16'h0000};
    end

    assign div_start = !r_launch && ((r_state == S_DIV_MEAN)
                     || ((r_state == S_DIV_VP) && cnt_ge1)
                     || ((r_state == S_DIV_VS) && cnt_ge2));
    assign mul_start = !r_launch && (r_state == S_MUL);
    assign sq_start  = !r_launch && ((r_state == S_SQ_VP) || (r_state == S_SQ_VS));

    rvw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    rvw_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (delta_mag),
        .i_b     (dev2_mag),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    rvw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (sq_val),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_sample_absent) n_state = S_DIV_MEAN;
                    else if (i_group_end) n_state = S_DIV_VP;
                end
            end
            S_DIV_MEAN: if (div_done) n_state = S_MUL;
            S_MUL:      if (mul_done) n_state = S_ACC;
            S_ACC:      n_state = r_end ? S_DIV_VP : S_IDLE;
            S_DIV_VP:   if (!cnt_ge1 || div_done) n_state = S_DIV_VS;
            S_DIV_VS:   if (!cnt_ge2 || div_done) n_state = S_SQ_VP;
            S_SQ_VP:    if (sq_done) n_state = S_SQ_VS;
            S_SQ_VS:    if (sq_done) n_state = S_OUT;
            S_OUT:      if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_launch  <= 1'b0;
            r_o_valid <= 1'b0;
            r_mean    <= '0;
            r_m2      <= '0;
            r_count   <= '0;
            r_sat     <= 1'b0;
            r_end     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (div_start || mul_start || sq_start) begin
                r_launch <= 1'b1;
            end else if (div_done || mul_done || sq_done) begin
                r_launch <= 1'b0;
            end
            if (r_state == S_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_end <= i_group_end;
                        if (!i_sample_absent) begin
                            if (r_count == COUNT_MAX) r_sat <= 1'b1;
                            else                      r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_DIV_MEAN: if (div_done) r_mean <= mean_next[MEAN_W-1:0];
                S_ACC: begin
                    if (m2_sum[M2_W]) begin
                        r_m2  <= '1;
                        r_sat <= 1'b1;
                    end else begin
                        r_m2 <= m2_sum[M2_W-1:0];
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_mean    <= '0;
                        r_m2      <= '0;
                        r_count   <= '0;
                        r_sat     <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_xq    <= xq_in;
            r_delta <= delta_in;
        end
        if (r_state == S_DIV_VP) begin
            if (!cnt_ge1)      r_vp <= '0;
            else if (div_done) r_vp <= quot_clamped;
        end
        if (r_state == S_DIV_VS) begin
            if (!cnt_ge2)      r_vs <= '0;
            else if (div_done) r_vs <= quot_clamped;
        end
        if (r_state == S_SQ_VP && sq_done) r_dp <= sq_root;
        if (r_state == S_OUT && out_free) begin
            o_variance_population  <= r_vp;
            o_variance_sample      <= r_vs;
            o_deviation_population <= r_dp;
            o_deviation_sample     <= sq_root;
            o_sample_count         <= 32'(r_count);
            o_population_valid     <= cnt_ge1;
            o_sample_stats_valid   <= cnt_ge2;
            o_overflow_flag        <= r_sat;
        end
    end

    assign o_valid = r_o_valid;

endmodule
